// ===== hdl/scli_pkg.sv =====
// Shared types, constants and helpers of the serial command line interpreter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package scli_pkg;

    // Bytes held in the line window
    localparam int unsigned WINDOW_BYTES = 4;

    // Powers of ten, used to size the decimal value of a line
    function automatic int unsigned pow10(input int unsigned n);
        int unsigned r;
        r = 1;
        for (int unsigned k = 0; k < n; k++) begin
            r = r * 10;
        end
        return r;
    endfunction

    localparam int unsigned FILL_W = $clog2(WINDOW_BYTES + 1);
    localparam int unsigned WIN_IDX_W = $clog2(WINDOW_BYTES);
    localparam int unsigned VAL_W = $clog2(pow10(WINDOW_BYTES - 1));

    // Line queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned Q_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character and setting constants
    localparam logic [7:0] BYTE_CR = 8'd13;
    localparam logic [7:0] BYTE_LF = 8'd10;
    localparam logic [7:0] BYTE_ZERO = 8'h30;
    localparam logic [7:0] BYTE_NINE = 8'h39;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [8:0] POWER_MAX = 9'd335;
    localparam logic [2:0] CHANNEL_DEFAULT = 3'd5;
    localparam logic [2:0] CHANNEL_MAX = 3'd7;
    localparam logic [2:0] CHANNEL_HOLE = 3'd6;

    // Reset values of the saved registers
    localparam logic [2:0] RST_CHANNEL = 3'd5;
    localparam logic [8:0] RST_TX_POWER = 9'd0;
    localparam logic RST_TABLE_OUTPUT = 1'b1;
    localparam logic RST_TAG_MODE = 1'b0;

    typedef enum logic [3:0] {
        CMD_UNKNOWN = 4'd0,
        CMD_F       = 4'd1,
        CMD_R       = 4'd2,
        CMD_C       = 4'd3,
        CMD_X       = 4'd4,
        CMD_T       = 4'd5,
        CMD_Q       = 4'd6,
        CMD_M       = 4'd7,
        CMD_S       = 4'd8
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_REFUSED   = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_NO_VALUE  = 3'd3,
        ST_BAD_VALUE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_SAVED_CHANNEL  = 2'd0,
        REG_SAVED_TX_POWER = 2'd1,
        REG_SAVED_TABLE    = 2'd2,
        REG_SAVED_TAG      = 2'd3
    } cfg_reg_t;

    // One classified line, passed from front to back
    typedef struct packed {
        cmd_code_t        code;
        logic             has_value;
        logic             digits_ok;
        logic [VAL_W-1:0] value;
    } line_desc_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic      reload_done;
        logic      store_request;
        logic      power_update;
        logic      radio_restart;
        logic      table_output_now;
        logic      command_mode_now;
        logic      tag_mode_now;
        logic [8:0] tx_power_now;
        logic [2:0] channel_now;
        status_t   status;
        cmd_code_t command_code;
    } result_t;

    localparam int unsigned RES_W = $bits(result_t);
    localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hdl/serial_command_line_interpreter.sv =====
// Serial command line interpreter: one received byte per input item, one result item
// per line end. The front end keeps the line window and classifies each line, a
// four-entry line queue decouples it from the back end, which applies the command to
// the working settings and holds the result in an output register. A byte is taken in
// every cycle while the line queue has room. Results pass the queue and the output
// register and leave at one per cycle while m_tready is high. Non-line-end bytes
// and an LF straight after a CR give no result. No clearing pass after reset.
// Depends on scli_pkg, scli_front, scli_queue and scli_exec.
`default_nettype none

module serial_command_line_interpreter
    import scli_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Received bytes
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] rx_byte
    // Result items
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [3:0] command_code, [6:4] status, [9:7] channel_now, [18:10] tx_power_now,
    // [19] tag_mode_now, [20] command_mode_now, [21] table_output_now,
    // [22] radio_restart, [23] power_update, [24] store_request, [25] reload_done
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // Configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [8:0]             cfg_data
);

    logic       push;
    line_desc_t push_desc;
    logic       pop;
    line_desc_t head_desc;
    logic       queue_full;
    logic       queue_empty;
    result_t    res;

    scli_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .queue_full (queue_full),
        .byte_ready (s_tready),
        .push       (push),
        .push_desc  (push_desc)
    );

    scli_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    scli_exec u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .head_desc   (head_desc),
        .queue_empty (queue_empty),
        .pop         (pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    // Pad the result to whole bytes
    assign m_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, res};

endmodule

`default_nettype wire

// ===== hdl/scli_front.sv =====
// Front end: takes received bytes, keeps the line window and classifies each line end.
// Depends on scli_pkg; feeds scli_queue.
`default_nettype none

module scli_front
    import scli_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    input  wire logic [7:0] byte_data,
    input  wire logic       queue_full,
    output logic            byte_ready,
    output logic            push,
    output line_desc_t      push_desc
);

    logic [7:0]        window_reg [WINDOW_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic              after_cr_reg;

    logic       take;
    logic       is_cr;
    logic       is_lf;
    logic       line_end;
    logic       swallow;
    logic [7:0] letter;
    logic [7:0] digit;
    logic       ok;
    logic [VAL_W-1:0] val;

    assign byte_ready = !queue_full;
    assign take       = byte_valid && byte_ready;
    assign is_cr      = (byte_data == BYTE_CR);
    assign is_lf      = (byte_data == BYTE_LF);
    assign line_end   = is_cr || is_lf;
    assign swallow    = is_lf && after_cr_reg;
    assign push       = take && line_end && !swallow;

    // Classify the line held in the window
    always_comb
    begin
        letter = window_reg[0] | CASE_BIT;
        unique case (letter)
            8'h66:   push_desc.code = CMD_F;
            8'h72:   push_desc.code = CMD_R;
            8'h63:   push_desc.code = CMD_C;
            8'h78:   push_desc.code = CMD_X;
            8'h74:   push_desc.code = CMD_T;
            8'h71:   push_desc.code = CMD_Q;
            8'h6d:   push_desc.code = CMD_M;
            8'h73:   push_desc.code = CMD_S;
            default: push_desc.code = CMD_UNKNOWN;
        endcase

        // decimal value of the bytes after the letter
        ok    = 1'b1;
        val   = '0;
        digit = '0;
        for (int i = 1; i < WINDOW_BYTES; i++) begin
            if (FILL_W'(i) < fill_reg) begin
                digit = window_reg[i] - BYTE_ZERO;
                if (window_reg[i] < BYTE_ZERO || window_reg[i] > BYTE_NINE) begin
                    ok = 1'b0;
                end else begin
                    val = val * VAL_W'(10) + VAL_W'(digit[3:0]);
                end
            end
        end
        push_desc.has_value = (fill_reg >= FILL_W'(2));
        push_desc.digits_ok = ok;
        push_desc.value     = val;
    end

    // Window, fill count and CR mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < WINDOW_BYTES; i++) begin
                window_reg[i] <= '0;
            end
            fill_reg     <= '0;
            after_cr_reg <= 1'b0;
        end else if (take) begin
            if (!line_end) begin
                after_cr_reg <= 1'b0;
                if (fill_reg == FILL_W'(WINDOW_BYTES)) begin
                    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
                        window_reg[i] <= window_reg[i + 1];
                    end
                    window_reg[WINDOW_BYTES - 1] <= byte_data;
                end else begin
                    window_reg[fill_reg[WIN_IDX_W-1:0]] <= byte_data;
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end else if (swallow) begin
                after_cr_reg <= 1'b0;
            end else begin
                after_cr_reg <= is_cr;
                for (int i = 0; i < WINDOW_BYTES; i++) begin
                    window_reg[i] <= '0;
                end
                fill_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/scli_queue.sv =====
// Short queue of classified lines between the front and back ends.
// Depends on scli_pkg.
`default_nettype none

module scli_queue
    import scli_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire line_desc_t push_desc,
    input  wire logic       pop,
    output line_desc_t      head_desc,
    output logic            full,
    output logic            empty
);

    line_desc_t         entry_reg [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0] wr_ptr_reg;
    logic [Q_IDX_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full      = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_desc = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_IDX_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_IDX_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/scli_exec.sv =====
// Back end: carries out classified lines, holds the working and saved settings
// and the result register. Depends on scli_pkg.
`default_nettype none

module scli_exec
    import scli_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data,
    input  wire line_desc_t head_desc,
    input  wire logic       queue_empty,
    output logic            pop,
    output logic            res_valid,
    input  wire logic       res_ready,
    output result_t         res
);

    localparam int unsigned CMP_W = (VAL_W > 9) ? VAL_W : 9;

    // Saved registers
    logic [2:0] saved_channel_reg;
    logic [8:0] saved_tx_power_reg;
    logic       saved_table_reg;
    logic       saved_tag_reg;

    // Working settings
    logic [2:0] channel_reg, channel_next;
    logic [8:0] tx_power_reg, tx_power_next;
    logic       table_reg, table_next;
    logic       tag_reg, tag_next;
    logic       cmd_mode_reg, cmd_mode_next;

    logic    res_valid_reg;
    result_t res_reg;

    status_t    status;
    logic       refused;
    logic       restart;
    logic       pupdate;
    logic       store;
    logic       reload;
    logic [CMP_W-1:0] val_ext;
    logic [CMP_W-1:0] ch_cand;
    logic [CMP_W-1:0] pw_cand;
    logic [2:0]  ch_fix;
    logic [8:0]  pw_cap;
    logic [16:0] pw_prod;
    logic [6:0]  pw_quot;
    logic [8:0]  pw_round;

    assign pop       = !queue_empty && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Candidate settings of a value write, corrected to the legal range
    always_comb
    begin
        val_ext = CMP_W'(head_desc.value);
        ch_cand = (head_desc.code == CMD_C) ? val_ext : CMP_W'(channel_reg);
        pw_cand = (head_desc.code == CMD_X) ? val_ext : CMP_W'(tx_power_reg);
        if (ch_cand == '0 || ch_cand > CMP_W'(CHANNEL_MAX)
            || ch_cand == CMP_W'(CHANNEL_HOLE)) begin
            ch_fix = CHANNEL_DEFAULT;
        end else begin
            ch_fix = ch_cand[2:0];
        end
        pw_cap   = (pw_cand > CMP_W'(POWER_MAX)) ? POWER_MAX : pw_cand[8:0];
        // divide by five through the reciprocal 205/1024, exact below 1024
        pw_prod  = 17'(pw_cap) * 17'd205;
        pw_quot  = pw_prod[16:10];
        pw_round = {pw_quot, 2'b00} + 9'(pw_quot);
    end

    // Command execution
    always_comb
    begin
        status        = ST_OK;
        restart       = 1'b0;
        pupdate       = 1'b0;
        store         = 1'b0;
        reload        = 1'b0;
        channel_next  = channel_reg;
        tx_power_next = tx_power_reg;
        table_next    = table_reg;
        tag_next      = tag_reg;
        cmd_mode_next = cmd_mode_reg;

        if (head_desc.code == CMD_M) begin
            refused = cmd_mode_reg;
        end else begin
            refused = (head_desc.code != CMD_UNKNOWN) && (head_desc.code != CMD_T)
                      && !cmd_mode_reg;
        end

        if (head_desc.code == CMD_UNKNOWN) begin
            status = ST_UNKNOWN;
        end else if (refused) begin
            status = ST_REFUSED;
        end else begin
            unique case (head_desc.code)
                CMD_F:
                begin
                    tag_next = !tag_reg;
                    restart  = 1'b1;
                end
                CMD_R:
                begin
                    channel_next  = saved_channel_reg;
                    tx_power_next = saved_tx_power_reg;
                    table_next    = saved_table_reg;
                    tag_next      = saved_tag_reg;
                    reload        = 1'b1;
                end
                CMD_T: table_next = !table_reg;
                CMD_Q: cmd_mode_next = 1'b0;
                CMD_M: cmd_mode_next = 1'b1;
                CMD_S: store = 1'b1;
                CMD_C, CMD_X:
                begin
                    if (!head_desc.has_value) begin
                        status = ST_NO_VALUE;
                    end else if (!head_desc.digits_ok) begin
                        status = ST_BAD_VALUE;
                    end else begin
                        channel_next  = ch_fix;
                        tx_power_next = pw_round;
                        if (ch_fix != channel_reg) begin
                            restart = 1'b1;
                        end else if (pw_round != tx_power_reg) begin
                            pupdate = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Saved registers, written from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            saved_channel_reg  <= RST_CHANNEL;
            saved_tx_power_reg <= RST_TX_POWER;
            saved_table_reg    <= RST_TABLE_OUTPUT;
            saved_tag_reg      <= RST_TAG_MODE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SAVED_CHANNEL:  saved_channel_reg  <= cfg_data[2:0];
                REG_SAVED_TX_POWER: saved_tx_power_reg <= cfg_data;
                REG_SAVED_TABLE:    saved_table_reg    <= cfg_data[0];
                REG_SAVED_TAG:      saved_tag_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Working settings and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            channel_reg   <= RST_CHANNEL;
            tx_power_reg  <= RST_TX_POWER;
            table_reg     <= RST_TABLE_OUTPUT;
            tag_reg       <= RST_TAG_MODE;
            cmd_mode_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else if (pop) begin
            channel_reg   <= channel_next;
            tx_power_reg  <= tx_power_next;
            table_reg     <= table_next;
            tag_reg       <= tag_next;
            cmd_mode_reg  <= cmd_mode_next;
            res_valid_reg <= 1'b1;
        end else if (res_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop) begin
            res_reg.command_code     <= head_desc.code;
            res_reg.status           <= status;
            res_reg.channel_now      <= channel_next;
            res_reg.tx_power_now     <= tx_power_next;
            res_reg.tag_mode_now     <= tag_next;
            res_reg.command_mode_now <= cmd_mode_next;
            res_reg.table_output_now <= table_next;
            res_reg.radio_restart    <= restart;
            res_reg.power_update     <= pupdate;
            res_reg.store_request    <= store;
            res_reg.reload_done      <= reload;
        end
    end

endmodule

`default_nettype wire
